>>> rtl/elrb_pkg.sv
// shared constants, command codes and control types for the event log
package elrb_pkg;

    // log geometry
    localparam int LOG_DEPTH  = 32;
    localparam int ENTRY_BITS = 64;
    localparam int IDX_W      = $clog2(LOG_DEPTH);
    localparam int CNT_W      = $clog2(LOG_DEPTH + 1);

    // beat field widths
    localparam int CMD_W   = 2;
    localparam int DATA_W  = 64;
    localparam int OFS_W   = 5;
    localparam int COUNT_W = 6;
    localparam int TALLY_W = 16;

    // width that holds both an offset and a count, and their sum with an index
    localparam int CMP_W = (CNT_W > OFS_W) ? CNT_W : OFS_W;
    localparam int SUM_W = CMP_W + 1;

    // configuration port
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;
    localparam int REG_IDX_W = APB_AW - 2;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    localparam reg_idx_t REG_LOG_MODE = 1'b0;

    localparam logic MODE_OVERWRITE = 1'b0;
    localparam logic MODE_DISCARD   = 1'b1;

    // command codes
    typedef logic [CMD_W-1:0] cmd_code_t;
    localparam cmd_code_t CMD_ADD   = 2'd0;
    localparam cmd_code_t CMD_CLEAR = 2'd1;
    localparam cmd_code_t CMD_READ  = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic op_add;
        logic op_clear;
        logic op_read;
        logic load_now;
        logic load_read;
    } dp_cmd_t;

endpackage

>>> rtl/elrb_if.sv
// beat channels of the event log: command input and result output
interface elrb_in_if;
    logic                         valid;
    logic                         ready;
    logic [elrb_pkg::CMD_W-1:0]   command;
    logic [elrb_pkg::DATA_W-1:0]  entry_data;
    logic [elrb_pkg::OFS_W-1:0]   read_offset;

    modport source (output valid, command, entry_data, read_offset, input ready);
    modport sink   (input valid, command, entry_data, read_offset, output ready);
endinterface

interface elrb_out_if;
    logic                          valid;
    logic                          ready;
    logic [elrb_pkg::DATA_W-1:0]   read_data;
    logic                          read_valid;
    logic                          stored;
    logic [elrb_pkg::COUNT_W-1:0]  entry_count;
    logic                          log_full;
    logic [elrb_pkg::TALLY_W-1:0]  overflow_count;

    modport source (output valid, read_data, read_valid, stored, entry_count, log_full,
                    overflow_count, input ready);
    modport sink   (input valid, read_data, read_valid, stored, entry_count, log_full,
                    overflow_count, output ready);
endinterface

>>> rtl/elrb_ctrl.sv
// controller: input/output handshake and read sequencing
module elrb_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  elrb_pkg::cmd_code_t command,
    input  logic                out_ready,
    output logic                in_ready,
    output logic                out_valid,
    output elrb_pkg::dp_cmd_t   cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;
    logic accept;

    // output register can take a new result
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;

    // command decode toward the datapath
    always_comb
    begin
        cmd.op_add    = accept && (command == elrb_pkg::CMD_ADD);
        cmd.op_clear  = accept && (command == elrb_pkg::CMD_CLEAR);
        cmd.op_read   = accept && (command == elrb_pkg::CMD_READ);
        cmd.load_now  = accept && (command != elrb_pkg::CMD_READ);
        cmd.load_read = (state_reg == S_READ) && out_free;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.op_read)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (cmd.load_read)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        priority if (cmd.load_now || cmd.load_read)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/elrb_dp.sv
// datapath: entry memory, ring pointers, counters and result register
module elrb_dp
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  elrb_pkg::dp_cmd_t                 cmd,
    input  logic                              log_mode,
    input  logic [elrb_pkg::DATA_W-1:0]       entry_data,
    input  logic [elrb_pkg::OFS_W-1:0]        read_offset,
    output logic [elrb_pkg::DATA_W-1:0]       read_data,
    output logic                              read_valid,
    output logic                              stored,
    output logic [elrb_pkg::COUNT_W-1:0]      entry_count,
    output logic                              log_full,
    output logic [elrb_pkg::TALLY_W-1:0]      overflow_count
);

    localparam int IDX_W   = elrb_pkg::IDX_W;
    localparam int CNT_W   = elrb_pkg::CNT_W;
    localparam int CMP_W   = elrb_pkg::CMP_W;
    localparam int SUM_W   = elrb_pkg::SUM_W;
    localparam int TALLY_W = elrb_pkg::TALLY_W;
    localparam int E_W     = elrb_pkg::ENTRY_BITS;

    // entry memory
    logic [E_W-1:0] mem [elrb_pkg::LOG_DEPTH];
    logic [E_W-1:0] mem_q;

    logic [IDX_W-1:0]   widx_reg;
    logic [IDX_W-1:0]   widx_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               full_reg;
    logic               full_next;
    logic [TALLY_W-1:0] tally_reg;
    logic [TALLY_W-1:0] tally_next;
    logic               rd_ok_reg;

    logic               add_wr;
    logic               rd_ok;
    logic [IDX_W-1:0]   oldest;
    logic [SUM_W-1:0]   slot_sum;
    logic [IDX_W-1:0]   slot;

    // result register
    logic [elrb_pkg::DATA_W-1:0]  rdata_reg;
    logic                         rvalid_reg;
    logic                         stored_reg;
    logic [elrb_pkg::COUNT_W-1:0] cnt_out_reg;
    logic                         full_out_reg;
    logic [TALLY_W-1:0]           tally_out_reg;

    // add writes unless full in discard mode
    assign add_wr = cmd.op_add && (!full_reg || (log_mode == elrb_pkg::MODE_OVERWRITE));

    // pointer and counter update
    always_comb
    begin
        widx_next  = widx_reg;
        count_next = count_reg;
        full_next  = full_reg;
        tally_next = tally_reg;
        if (cmd.op_clear)
        begin
            widx_next  = '0;
            count_next = '0;
            full_next  = 1'b0;
            tally_next = '0;
        end
        else if (cmd.op_add)
        begin
            if (full_reg)
            begin
                tally_next = tally_reg + TALLY_W'(1);
            end
            if (add_wr)
            begin
                widx_next = (widx_reg == IDX_W'(elrb_pkg::LOG_DEPTH - 1)) ?
                            '0 : widx_reg + IDX_W'(1);
                if (count_reg != CNT_W'(elrb_pkg::LOG_DEPTH))
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                if (count_reg == CNT_W'(elrb_pkg::LOG_DEPTH - 1))
                begin
                    full_next = 1'b1;
                end
            end
        end
    end

    // age to slot mapping
    assign oldest   = full_reg ? widx_reg : '0;
    assign rd_ok    = CMP_W'(read_offset) < CMP_W'(count_reg);
    assign slot_sum = SUM_W'(oldest) + SUM_W'(read_offset);
    assign slot     = (slot_sum >= SUM_W'(elrb_pkg::LOG_DEPTH)) ?
                      IDX_W'(slot_sum - SUM_W'(elrb_pkg::LOG_DEPTH)) : IDX_W'(slot_sum);

    // memory write port and registered read port
    always_ff @(posedge clk)
    begin
        if (add_wr)
        begin
            mem[widx_reg] <= entry_data[E_W-1:0];
        end
        if (cmd.op_read)
        begin
            mem_q <= mem[slot];
        end
    end

    // ring state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            widx_reg  <= '0;
            count_reg <= '0;
            full_reg  <= 1'b0;
            tally_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            widx_reg  <= widx_next;
            count_reg <= count_next;
            full_reg  <= full_next;
            tally_reg <= tally_next;
            if (cmd.op_read)
            begin
                rd_ok_reg <= rd_ok;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_now)
        begin
            rdata_reg     <= '0;
            rvalid_reg    <= 1'b0;
            stored_reg    <= add_wr;
            cnt_out_reg   <= elrb_pkg::COUNT_W'(count_next);
            full_out_reg  <= full_next;
            tally_out_reg <= tally_next;
        end
        else if (cmd.load_read)
        begin
            rdata_reg     <= rd_ok_reg ? elrb_pkg::DATA_W'(mem_q) : '0;
            rvalid_reg    <= rd_ok_reg;
            stored_reg    <= 1'b0;
            cnt_out_reg   <= elrb_pkg::COUNT_W'(count_reg);
            full_out_reg  <= full_reg;
            tally_out_reg <= tally_reg;
        end
    end

    assign read_data      = rdata_reg;
    assign read_valid     = rvalid_reg;
    assign stored         = stored_reg;
    assign entry_count    = cnt_out_reg;
    assign log_full       = full_out_reg;
    assign overflow_count = tally_out_reg;

endmodule

>>> rtl/event_log_ring_buffer_top.sv
// top level of the event log ring buffer: channels, register port, assertions
//
// Fixed-depth log of 32 entry words in a ring, with add, clear and read-by-age
// commands and an overwrite or discard policy when full (register log_mode at
// byte address 0). Add, clear and unused commands load their result into the
// output register at the edge the beat is accepted. A read passes through the
// registered read port of the entry memory and then the result register; one
// item is in flight at a time, and the next beat is taken in the same cycle
// that a waiting result is taken. Entries hold no reset value, so a freshly
// reset or cleared log needs no clearing pass and accepts beats at once.
module event_log_ring_buffer_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    elrb_in_if.sink                       in_ch,
    elrb_out_if.source                    out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [elrb_pkg::APB_AW-1:0]   paddr,
    input  logic [elrb_pkg::APB_DW-1:0]   pwdata,
    output logic [elrb_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    elrb_pkg::dp_cmd_t   cmd;
    elrb_pkg::reg_idx_t  reg_idx;
    logic                log_mode_reg;
    logic                cfg_wr;

    // register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[elrb_pkg::APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (reg_idx == elrb_pkg::REG_LOG_MODE) ?
                     elrb_pkg::APB_DW'(log_mode_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_mode_reg <= elrb_pkg::MODE_OVERWRITE;
        end
        else if (cfg_wr && (reg_idx == elrb_pkg::REG_LOG_MODE))
        begin
            log_mode_reg <= pwdata[0];
        end
    end

    // controller
    elrb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .command   (in_ch.command),
        .out_ready (out_ch.ready),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .cmd       (cmd)
    );

    // datapath
    elrb_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .log_mode       (log_mode_reg),
        .entry_data     (in_ch.entry_data),
        .read_offset    (in_ch.read_offset),
        .read_data      (out_ch.read_data),
        .read_valid     (out_ch.read_valid),
        .stored         (out_ch.stored),
        .entry_count    (out_ch.entry_count),
        .log_full       (out_ch.log_full),
        .overflow_count (out_ch.overflow_count)
    );

    // no new beat while a read result is being fetched
    a_no_accept_during_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_read |-> !in_ch.ready)
        else $error("input ready while a read is in flight");

    // an accepted read is followed on the next cycle by the load of its result
    a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && (in_ch.command == elrb_pkg::CMD_READ))
        |=> cmd.load_read)
        else $error("read result not loaded one cycle after the read beat");

    // full flag agrees with the reported count
    a_full_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> ((out_ch.log_full ==
            (out_ch.entry_count == elrb_pkg::COUNT_W'(elrb_pkg::LOG_DEPTH)))
            && (out_ch.entry_count <= elrb_pkg::COUNT_W'(elrb_pkg::LOG_DEPTH))))
        else $error("log_full disagrees with entry_count");

    // a result is never both a stored add and a valid read
    a_stored_or_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !(out_ch.stored && out_ch.read_valid))
        else $error("result flags both stored and read_valid");

endmodule

>>> tb/event_log_ring_buffer_top_test.sv
// self-checking testbench for the event log ring buffer top level
module event_log_ring_buffer_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                 CLK_PERIOD     = 20;
    localparam int                 RESET_CYCLES   = 8;
    localparam int                 WATCHDOG_LIMIT = 500;
    localparam int                 SETTLE_CYCLES  = 4;
    localparam int                 MAX_GAP        = 13;
    localparam elrb_pkg::cmd_code_t CMD_UNUSED    = 2'd3;
    localparam elrb_pkg::reg_idx_t  REG_UNMAPPED  = 1'b1;

    // one command beat and the status beat it returns
    typedef struct packed {
        elrb_pkg::cmd_code_t                command;
        logic [elrb_pkg::DATA_W-1:0]        entry_data;
        logic [elrb_pkg::OFS_W-1:0]         read_offset;
    } log_cmd_t;

    typedef struct packed {
        logic [elrb_pkg::DATA_W-1:0]        read_data;
        logic                               read_valid;
        logic                               stored;
        logic [elrb_pkg::COUNT_W-1:0]       entry_count;
        logic                               log_full;
        logic [elrb_pkg::TALLY_W-1:0]       overflow_count;
    } log_status_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [elrb_pkg::APB_AW-1:0]    paddr;
    logic [elrb_pkg::APB_DW-1:0]    pwdata;
    logic [elrb_pkg::APB_DW-1:0]    prdata;
    logic                           pready;

    elrb_in_if  in_ch();
    elrb_out_if out_ch();

    event_log_ring_buffer_top dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // mirror of the log state
    logic [elrb_pkg::DATA_W-1:0]    mirror_store [elrb_pkg::LOG_DEPTH];
    int                             mirror_wr    = 0;
    int                             mirror_held  = 0;
    logic                           mirror_full  = 1'b0;
    logic [elrb_pkg::TALLY_W-1:0]   mirror_tally = '0;
    logic                           mirror_mode  = elrb_pkg::MODE_OVERWRITE;

    log_cmd_t           cmd_backlog [$];
    log_status_t        predicted_status [$];
    log_cmd_t           cur_cmd;
    log_status_t        got_status;
    log_status_t        want_status;
    logic               next_valid;
    logic               field_bad;
    logic               draining = 1'b0;

    int                 send_gap     = 0;
    int                 recv_stall   = 0;
    int                 in_idle_pct  = 0;
    int                 out_idle_pct = 0;
    int                 idle_cycles  = 0;
    int                 mismatches   = 0;
    int                 beats_in     = 0;
    int                 beats_out    = 0;
    int                 n_add        = 0;
    int                 n_discard    = 0;
    int                 n_read       = 0;
    int                 n_read_hit   = 0;
    int                 n_clear      = 0;
    int                 n_unused     = 0;
    int                 n_reg_writes = 0;

    // clock
    always
    begin
        #(CLK_PERIOD / 2) clk = ~clk;
    end

    // next status of the log for one command, updating the mirror
    function automatic log_status_t log_mirror_step(log_cmd_t c);
        log_status_t                s;
        logic [elrb_pkg::IDX_W-1:0] slot;
        s = '0;
        case (c.command)
            elrb_pkg::CMD_ADD:
            begin
                n_add++;
                if (mirror_full)
                begin
                    mirror_tally = mirror_tally + 1'b1;
                end
                if (!mirror_full || mirror_mode == elrb_pkg::MODE_OVERWRITE)
                begin
                    mirror_store[elrb_pkg::IDX_W'(mirror_wr)] = c.entry_data;
                    s.stored = 1'b1;
                    mirror_wr++;
                    if (mirror_wr >= elrb_pkg::LOG_DEPTH)
                        mirror_wr = 0;
                    if (mirror_held < elrb_pkg::LOG_DEPTH)
                    begin
                        mirror_held++;
                        if (mirror_held == elrb_pkg::LOG_DEPTH)
                            mirror_full = 1'b1;
                    end
                end
                else
                    n_discard++;
            end
            elrb_pkg::CMD_CLEAR:
            begin
                n_clear++;
                mirror_wr    = 0;
                mirror_held  = 0;
                mirror_full  = 1'b0;
                mirror_tally = '0;
            end
            elrb_pkg::CMD_READ:
            begin
                n_read++;
                if (c.read_offset < mirror_held)
                begin
                    // oldest entry sits at the write index once the ring is full
                    slot = elrb_pkg::IDX_W'((((mirror_held == elrb_pkg::LOG_DEPTH) ?
                           mirror_wr : 0) + c.read_offset) % elrb_pkg::LOG_DEPTH);
                    s.read_data  = mirror_store[slot];
                    s.read_valid = 1'b1;
                    n_read_hit++;
                end
            end
            default:
                n_unused++;
        endcase
        s.entry_count    = elrb_pkg::COUNT_W'(mirror_held);
        s.log_full       = mirror_full;
        s.overflow_count = mirror_tally;
        return s;
    endfunction

    function automatic log_cmd_t make_cmd(elrb_pkg::cmd_code_t code,
                                          logic [elrb_pkg::DATA_W-1:0] data,
                                          logic [elrb_pkg::OFS_W-1:0] ofs);
        log_cmd_t c;
        c.command     = code;
        c.entry_data  = data;
        c.read_offset = ofs;
        return c;
    endfunction

    // random command, weights out of 1000, remainder goes to the unused code
    function automatic log_cmd_t rand_cmd(int unsigned add_w, int unsigned read_w,
                                          int unsigned clear_w);
        log_cmd_t    c;
        int unsigned pick;
        pick = $urandom_range(0, 999);
        if (pick < add_w)
            c.command = elrb_pkg::CMD_ADD;
        else if (pick < add_w + read_w)
            c.command = elrb_pkg::CMD_READ;
        else if (pick < add_w + read_w + clear_w)
            c.command = elrb_pkg::CMD_CLEAR;
        else
            c.command = CMD_UNUSED;
        case ($urandom_range(0, 15))
            0:       c.entry_data = '0;
            1:       c.entry_data = '1;
            default: c.entry_data = {$urandom, $urandom};
        endcase
        if ($urandom_range(0, 1) != 0)
            c.read_offset = elrb_pkg::OFS_W'($urandom_range(0, 31));
        else
            c.read_offset = elrb_pkg::OFS_W'($urandom_range(0, 3));
        return c;
    endfunction

    task automatic queue_random(int count, int unsigned add_w, int unsigned read_w,
                                int unsigned clear_w);
        repeat (count)
            cmd_backlog.push_back(rand_cmd(add_w, read_w, clear_w));
    endtask

    // register write: setup then access, done when pready is seen in access
    task automatic reg_write(elrb_pkg::reg_idx_t idx, logic [elrb_pkg::APB_DW-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == elrb_pkg::REG_LOG_MODE)
            mirror_mode = data[0];
        n_reg_writes++;
    endtask

    // block idle: nothing queued, nothing in flight
    task automatic wait_drained();
        do
            @(negedge clk);
        while (cmd_backlog.size() != 0 || in_ch.valid || predicted_status.size() != 0
               || out_ch.valid);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic report_mismatch(string what, log_status_t want, log_status_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t: %s", $time, what);
            $display("  expected data=%h rvalid=%b stored=%b count=%0d full=%b ovf=%0d",
                     want.read_data, want.read_valid, want.stored, want.entry_count,
                     want.log_full, want.overflow_count);
            $display("  actual   data=%h rvalid=%b stored=%b count=%0d full=%b ovf=%0d",
                     got.read_data, got.read_valid, got.stored, got.entry_count,
                     got.log_full, got.overflow_count);
        end
    endtask

    // command driver fed from the backlog
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            send_gap = 0;
            draining = 1'b0;
        end
        else
        begin
            // beat taken: predict its status
            if (in_ch.valid && in_ch.ready)
            begin
                predicted_status.push_back(log_mirror_step(cur_cmd));
                beats_in++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                next_valid = 1'b0;
                if (draining)
                begin
                    if (predicted_status.size() == 0)
                        draining = 1'b0;
                end
                else if (send_gap != 0)
                    send_gap--;
                else if (cmd_backlog.size() != 0)
                begin
                    cur_cmd = cmd_backlog.pop_front();
                    next_valid = 1'b1;
                    in_ch.command     <= cur_cmd.command;
                    in_ch.entry_data  <= cur_cmd.entry_data;
                    in_ch.read_offset <= cur_cmd.read_offset;
                    // occasional gap burst, rarely a full drain of the pending results
                    if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct)
                        send_gap = $urandom_range(1, MAX_GAP);
                    else if (in_idle_pct != 0 && $urandom_range(0, 299) == 0)
                        draining = 1'b1;
                end
                in_ch.valid <= next_valid;
            end
        end
    end

    // status monitor and checker
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got_status.read_data      = out_ch.read_data;
                got_status.read_valid     = out_ch.read_valid;
                got_status.stored         = out_ch.stored;
                got_status.entry_count    = out_ch.entry_count;
                got_status.log_full       = out_ch.log_full;
                got_status.overflow_count = out_ch.overflow_count;
                beats_out++;
                if (predicted_status.size() == 0)
                    report_mismatch("status beat with nothing expected", '0, got_status);
                else
                begin
                    want_status = predicted_status.pop_front();
                    field_bad = (got_status.read_data !== want_status.read_data)
                             || (got_status.read_valid !== want_status.read_valid)
                             || (got_status.stored !== want_status.stored)
                             || (got_status.entry_count !== want_status.entry_count)
                             || (got_status.log_full !== want_status.log_full)
                             || (got_status.overflow_count !== want_status.overflow_count);
                    if (field_bad)
                        report_mismatch("status mismatch", want_status, got_status);
                end
            end
            // receiver stall bursts
            if (recv_stall != 0)
            begin
                recv_stall--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct)
                    recv_stall = $urandom_range(1, MAX_GAP);
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("event_log_ring_buffer_top_test: done, errors");
            $finish;
        end
    end

    // stimulus sequence
    initial
    begin
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.command     = elrb_pkg::CMD_ADD;
        in_ch.entry_data  = '0;
        in_ch.read_offset = '0;
        out_ch.ready      = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset policy, empty reads, extremes, clear, unused code
        in_idle_pct  = 20;
        out_idle_pct = 20;
        cmd_backlog.push_back(make_cmd(elrb_pkg::CMD_READ, '0, 5'd0));
        cmd_backlog.push_back(make_cmd(elrb_pkg::CMD_READ, '1, 5'd31));
        cmd_backlog.push_back(make_cmd(CMD_UNUSED, '1, 5'd31));
        cmd_backlog.push_back(make_cmd(elrb_pkg::CMD_ADD, '0, 5'd0));
        cmd_backlog.push_back(make_cmd(elrb_pkg::CMD_ADD, '1, 5'd31));
        cmd_backlog.push_back(make_cmd(elrb_pkg::CMD_ADD, 64'hA5A5_5A5A_C3C3_3C3C, 5'd0));
        cmd_backlog.push_back(make_cmd(elrb_pkg::CMD_READ, '0, 5'd0));
        cmd_backlog.push_back(make_cmd(elrb_pkg::CMD_READ, '0, 5'd1));
        cmd_backlog.push_back(make_cmd(elrb_pkg::CMD_READ, '0, 5'd2));
        cmd_backlog.push_back(make_cmd(elrb_pkg::CMD_READ, '0, 5'd3));
        cmd_backlog.push_back(make_cmd(elrb_pkg::CMD_READ, '1, 5'd31));
        cmd_backlog.push_back(make_cmd(CMD_UNUSED, '0, 5'd0));
        cmd_backlog.push_back(make_cmd(elrb_pkg::CMD_READ, '0, 5'd2));
        cmd_backlog.push_back(make_cmd(elrb_pkg::CMD_CLEAR, '1, 5'd31));
        cmd_backlog.push_back(make_cmd(elrb_pkg::CMD_READ, '0, 5'd0));
        cmd_backlog.push_back(make_cmd(elrb_pkg::CMD_ADD, 64'h8000_0000_0000_0001, 5'd0));
        cmd_backlog.push_back(make_cmd(elrb_pkg::CMD_READ, '0, 5'd0));
        cmd_backlog.push_back(make_cmd(elrb_pkg::CMD_READ, '0, 5'd1));
        cmd_backlog.push_back(make_cmd(elrb_pkg::CMD_ADD, 64'h0123_4567_89AB_CDEF, 5'd17));
        cmd_backlog.push_back(make_cmd(elrb_pkg::CMD_READ, '0, 5'd1));
        cmd_backlog.push_back(make_cmd(elrb_pkg::CMD_CLEAR, '0, 5'd0));
        cmd_backlog.push_back(make_cmd(CMD_UNUSED, '0, 5'd0));
        wait_drained();

        // discard policy, add heavy so the ring fills and drops
        reg_write(elrb_pkg::REG_LOG_MODE, 32'h0000_0001);
        in_idle_pct  = $urandom_range(5, 40);
        out_idle_pct = $urandom_range(5, 40);
        queue_random(400, 650, 330, 8);
        wait_drained();

        // unmapped register must leave the policy alone
        reg_write(REG_UNMAPPED, 32'h0000_0000);
        in_idle_pct  = $urandom_range(0, 30);
        out_idle_pct = $urandom_range(0, 30);
        queue_random(300, 500, 470, 15);
        wait_drained();

        // overwrite policy with upper value bits set
        reg_write(elrb_pkg::REG_LOG_MODE, 32'hFFFF_FFFE);
        in_idle_pct  = $urandom_range(5, 40);
        out_idle_pct = $urandom_range(5, 40);
        queue_random(400, 600, 370, 12);
        wait_drained();

        // full run in discard mode, adds past the depth bump the tally, no idling
        reg_write(elrb_pkg::REG_LOG_MODE, 32'h0000_0001);
        in_idle_pct  = 0;
        out_idle_pct = 0;
        cmd_backlog.push_back(make_cmd(elrb_pkg::CMD_CLEAR, '0, 5'd0));
        for (int i = 0; i < elrb_pkg::LOG_DEPTH + 64; i++)
        begin
            if (i % 17 == 16)
                cmd_backlog.push_back(make_cmd(elrb_pkg::CMD_READ, '0,
                                               5'($urandom_range(0, 31))));
            else
                cmd_backlog.push_back(make_cmd(elrb_pkg::CMD_ADD, {$urandom, $urandom},
                                               5'd0));
        end
        wait_drained();

        // mixed traffic in discard mode with idling
        in_idle_pct  = $urandom_range(5, 40);
        out_idle_pct = $urandom_range(5, 40);
        queue_random(200, 550, 420, 10);
        wait_drained();

        // closing stretch in overwrite mode, no idling
        reg_write(elrb_pkg::REG_LOG_MODE, 32'h0000_0000);
        in_idle_pct  = 0;
        out_idle_pct = 0;
        queue_random(250, 600, 380, 12);
        wait_drained();

        $display("covered %0d commands: %0d adds (%0d dropped while full),",
                 beats_in, n_add, n_discard);
        $display("  %0d reads (%0d in range), %0d clears, %0d unused codes,",
                 n_read, n_read_hit, n_clear, n_unused);
        $display("  %0d register writes, %0d beats checked", n_reg_writes, beats_out);
        if (mismatches == 0)
            $display("event_log_ring_buffer_top_test: done, clean");
        else
            $display("event_log_ring_buffer_top_test: done, errors");
        $finish;
    end

endmodule
